// ===== hdl/windowed_rms_level_meter_unit_assert.svh =====
// Assertion macros used by the level meter checker.
`ifndef WINDOWED_RMS_LEVEL_METER_UNIT_ASSERT_SVH
`define WINDOWED_RMS_LEVEL_METER_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define WRMS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("level meter assertion failed");

// Next-cycle implication, held off during reset.
`define WRMS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("level meter assertion failed");

`endif

// ===== hdl/wrms_pkg.sv =====
// Widths, constants and shared types of the windowed RMS level meter.
package wrms_pkg;

  localparam int SAMPLE_SHIFT = 8;
  localparam int SAMPLE_W     = 32 - SAMPLE_SHIFT;
  localparam int SQ_W         = 2 * SAMPLE_W;
  localparam int COUNT_W      = 13;
  localparam int SUM_W        = 36;
  localparam int SQSUM_W      = 59;
  localparam int LEVEL_W      = 17;
  localparam int D_W          = 72;
  localparam int ROOT_W       = D_W / 2;
  localparam int REM_W        = ROOT_W + 4;
  localparam int FRAC_DROP    = 23 - 16;
  localparam int DQ_W         = ROOT_W - FRAC_DROP;
  localparam int STEP_W       = 6;

  localparam logic [COUNT_W-1:0] MAX_WINDOW    = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] WINDOW_RESET  = COUNT_W'(1024);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = LEVEL_W'(65536);

  typedef struct packed {
    logic [COUNT_W-1:0] n;
    logic [SQSUM_W-1:0] square_sum;
    logic [SUM_W-1:0]   sum_mag;
  } calc_operands_t;

endpackage

// ===== hdl/wrms_level_calc.sv =====
// Window-end level computation on one shared add/subtract unit.
module wrms_level_calc import wrms_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  calc_operands_t      operands,
  output logic                done,
  output logic [LEVEL_W-1:0]  level
);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_NSQ  = 6'b000010,
    C_SSQ  = 6'b000100,
    C_SQRT = 6'b001000,
    C_DIV  = 6'b010000,
    C_DONE = 6'b100000
  } calc_state_t;

  calc_state_t        state;
  calc_operands_t     ops;
  logic [STEP_W-1:0]  step;
  logic [D_W-1:0]     acc;
  logic [D_W-1:0]     mcand;
  logic [SUM_W-1:0]   mplier;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  root_next;
  logic [DQ_W-1:0]    dq;

  logic [D_W-1:0]     alu_a;
  logic [D_W-1:0]     alu_b;
  logic               alu_sub;
  logic [D_W:0]       alu_sum;
  logic [D_W-1:0]     alu_res;
  logic               alu_ge;
  logic [REM_W-1:0]   rem_sh_sqrt;
  logic [REM_W-1:0]   rem_sh_div;

  assign rem_sh_sqrt = {rem[REM_W-3:0], acc[D_W-1 -: 2]};
  assign rem_sh_div  = {rem[REM_W-2:0], dq[DQ_W-1]};

  // operand selection for the shared unit
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      C_NSQ: begin
        alu_b = mplier[0] ? mcand : '0;
      end
      C_SSQ: begin
        alu_b   = mplier[0] ? mcand : '0;
        alu_sub = 1'b1;
      end
      C_SQRT: begin
        alu_a   = D_W'(rem_sh_sqrt);
        alu_b   = D_W'({root, 2'b01});
        alu_sub = 1'b1;
      end
      C_DIV: begin
        alu_a   = D_W'(rem_sh_div);
        alu_b   = D_W'(ops.n);
        alu_sub = 1'b1;
      end
      C_IDLE, C_DONE: begin
        alu_a = acc;
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  // carry out of a subtract is set when a >= b
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (D_W+1)'(alu_sub);
  assign alu_res = alu_sum[D_W-1:0];
  assign alu_ge  = alu_sum[D_W];

  assign root_next = {root[ROOT_W-2:0], alu_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            ops    <= operands;
            acc    <= '0;
            mcand  <= D_W'(operands.square_sum);
            mplier <= SUM_W'(operands.n);
            step   <= STEP_W'(COUNT_W - 1);
            state  <= C_NSQ;
          end
        end
        // n * sum of squares, shift and add
        C_NSQ: begin
          acc    <= alu_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step - 1'b1;
          if (step == '0) begin
            mcand  <= D_W'(ops.sum_mag);
            mplier <= ops.sum_mag;
            step   <= STEP_W'(SUM_W - 1);
            state  <= C_SSQ;
          end
        end
        // subtract sum^2; partial results never drop below zero
        C_SSQ: begin
          acc    <= alu_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step - 1'b1;
          if (step == '0) begin
            rem   <= '0;
            root  <= '0;
            step  <= STEP_W'(ROOT_W - 1);
            state <= C_SQRT;
          end
        end
        // restoring square root, two radicand bits per step
        C_SQRT: begin
          acc  <= acc << 2;
          rem  <= alu_ge ? alu_res[REM_W-1:0] : rem_sh_sqrt;
          root <= root_next;
          step <= step - 1'b1;
          if (step == '0) begin
            rem   <= '0;
            dq    <= root_next[ROOT_W-1 -: DQ_W];
            step  <= STEP_W'(DQ_W - 1);
            state <= C_DIV;
          end
        end
        // restoring divide of root/128 by n; quotient shifts into dq
        C_DIV: begin
          rem  <= alu_ge ? alu_res[REM_W-1:0] : rem_sh_div;
          dq   <= {dq[DQ_W-2:0], alu_ge};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= C_DONE;
          end
        end
        C_DONE: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign done  = (state == C_DONE);
  assign level = (dq > DQ_W'(LEVEL_MAX)) ? LEVEL_MAX : dq[LEVEL_W-1:0];

endmodule

// ===== hdl/windowed_rms_level_meter_unit.sv =====
// Top level of the windowed RMS level meter.
//
//  channel        | handshake                       | payload
//  ---------------+---------------------------------+----------------------
//  sample in      | sample_valid / sample_ready     | sample_word [31:0]
//  level out      | level_valid / level_ready       | level [16:0]
//  window config  | window_length_write             | window_length [12:0]
//
// A sample is accepted, squared (24x24 multiply) and accumulated before the next is accepted.
// The last sample of a window then goes through a launch state, then
// 13 + 36 + 36 + 29 steps of the shared add/subtract unit (n*sumsq, sum^2,
// square root, divide by n), a done state and a load of the output.
// Samples are refused from the launch until the level is loaded; the load waits
// while an earlier level is still unaccepted.
// Synchronous reset clears control state; window length resets to 1024.
module windowed_rms_level_meter_unit import wrms_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic [31:0]         sample_word,
  output logic                level_valid,
  input  logic                level_ready,
  output logic [LEVEL_W-1:0]  level,
  input  logic                window_length_write,
  input  logic [COUNT_W-1:0]  window_length
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ACCUM  = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_CALC   = 6'b010000,
    ST_OUT    = 6'b100000
  } top_state_t;

  top_state_t                 state;
  logic [COUNT_W-1:0]         window_reg;
  logic [COUNT_W-1:0]         eff_window;
  logic [COUNT_W-1:0]         window_fill;
  logic [COUNT_W-1:0]         count_next;
  logic signed [SUM_W-1:0]    running_sum;
  logic [SQSUM_W-1:0]         running_square_sum;
  logic signed [SAMPLE_W-1:0] sample_s;
  logic [SAMPLE_W-1:0]        sample_mag;
  logic [SQ_W-1:0]            square;
  logic signed [SAMPLE_W-1:0] word_s;
  calc_operands_t             calc_ops;
  logic                       calc_start;
  logic                       calc_done;
  logic [LEVEL_W-1:0]         calc_level;
  logic                       out_free;

  always_comb begin
    if (window_reg == '0) begin
      eff_window = COUNT_W'(1);
    end else if (window_reg > MAX_WINDOW) begin
      eff_window = MAX_WINDOW;
    end else begin
      eff_window = window_reg;
    end
  end

  assign word_s     = $signed(sample_word[31:SAMPLE_SHIFT]);
  assign count_next = window_fill + 1'b1;
  assign out_free   = !level_valid || level_ready;
  assign sample_ready = (state == ST_IDLE);
  assign calc_start = (state == ST_LAUNCH);

  assign calc_ops.n          = window_fill;
  assign calc_ops.square_sum = running_square_sum;
  assign calc_ops.sum_mag    = running_sum[SUM_W-1] ? SUM_W'(-running_sum)
                                                    : SUM_W'(running_sum);

  wrms_level_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .start    (calc_start),
    .operands (calc_ops),
    .done     (calc_done),
    .level    (calc_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= WINDOW_RESET;
    end else if (window_length_write) begin
      window_reg <= window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      window_fill        <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            sample_s   <= word_s;
            sample_mag <= word_s[SAMPLE_W-1] ? SAMPLE_W'(-word_s) : SAMPLE_W'(word_s);
            state      <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          square <= sample_mag * sample_mag;
          state  <= ST_ACCUM;
        end
        ST_ACCUM: begin
          running_sum        <= running_sum + SUM_W'(sample_s);
          running_square_sum <= running_square_sum + SQSUM_W'(square);
          window_fill        <= count_next;
          state              <= (count_next >= eff_window) ? ST_LAUNCH : ST_IDLE;
        end
        // calc latches the operands; accumulators start the next window
        ST_LAUNCH: begin
          window_fill        <= '0;
          running_sum        <= '0;
          running_square_sum <= '0;
          state              <= ST_CALC;
        end
        ST_CALC: begin
          if (calc_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      level_valid <= 1'b1;
    end else if (level_ready) begin
      level_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      level <= calc_level;
    end
  end

endmodule

// ===== hdl/wrms_checker.sv =====
// Port-level checker for the windowed RMS level meter, bound to the top level.
`include "windowed_rms_level_meter_unit_assert.svh"

module wrms_checker import wrms_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_ready,
  input logic                level_valid,
  input logic                level_ready,
  input logic [LEVEL_W-1:0]  level
);

  // a level never exceeds full scale
  `WRMS_ASSERT_NOW(a_level_capped, clk, rst, level_valid, level <= LEVEL_MAX)

  // sample_ready falls once a sample is accepted
  `WRMS_ASSERT_NEXT(a_busy_after_request, clk, rst, sample_valid && sample_ready, !sample_ready)

  // a stalled result holds
  `WRMS_ASSERT_NEXT(a_level_held, clk, rst, level_valid && !level_ready,
                    level_valid && $stable(level))

endmodule

bind windowed_rms_level_meter_unit wrms_checker u_wrms_checker (.*);
